FILE: rtl/core/usbsof_pkg.sv
// ----------------------------------------------------------------------------
// usbsof_pkg
// Shared types and constants for the USB SOF keep-alive detector.
// ----------------------------------------------------------------------------
package usbsof_pkg;

  localparam int unsigned FRAME_W   = 11;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned PERIOD_W  = 10;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned LIMIT_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    ACT_SOF     = 2'd0,
    ACT_SUSPEND = 2'd1,
    ACT_RESUME  = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

  localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 10'd100;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 8'd3;

  typedef struct packed {
    logic [PERIOD_W-1:0]  period;
    logic [TIMEOUT_W-1:0] timeout;
    logic [LIMIT_W-1:0]   limit;
  } cfg_t;

  typedef struct packed {
    logic               link_active;
    logic               state_changed;
    logic [COUNT_W-1:0] sof_count;
  } result_t;

endpackage

FILE: rtl/core/usbsof_cfg.sv
// ----------------------------------------------------------------------------
// usbsof_cfg
// Configuration registers: monitor period, idle timeout, suspend limit.
// ----------------------------------------------------------------------------
module usbsof_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [usbsof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [usbsof_pkg::CFG_DAT_W-1:0]   cfg_data,
  output usbsof_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period  <= usbsof_pkg::PERIOD_RST;
      cfg.timeout <= usbsof_pkg::TIMEOUT_RST;
      cfg.limit   <= usbsof_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        usbsof_pkg::CFG_PERIOD:  cfg.period  <= cfg_data[usbsof_pkg::PERIOD_W-1:0];
        usbsof_pkg::CFG_TIMEOUT: cfg.timeout <= cfg_data[usbsof_pkg::TIMEOUT_W-1:0];
        usbsof_pkg::CFG_LIMIT:   cfg.limit   <= cfg_data[usbsof_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/usbsof_core.sv
// ----------------------------------------------------------------------------
// usbsof_core
// Link state registers and the per-item update logic.
// ----------------------------------------------------------------------------
module usbsof_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  usbsof_pkg::action_t                act,
  input  logic [usbsof_pkg::FRAME_W-1:0]     frame,
  input  usbsof_pkg::cfg_t                   cfg,
  output usbsof_pkg::result_t                res_next
);

  logic [usbsof_pkg::FRAME_W-1:0]   last_frame, last_frame_next;
  logic [usbsof_pkg::COUNT_W-1:0]   frame_counter, frame_counter_next;
  logic [usbsof_pkg::COUNT_W-1:0]   counter_snapshot, counter_snapshot_next;
  logic                             active_flag, active_flag_next;
  logic [usbsof_pkg::LIMIT_W-1:0]   suspend_events, suspend_events_next;
  logic [usbsof_pkg::TIMEOUT_W-1:0] idle_time_ms, idle_time_ms_next;
  logic [usbsof_pkg::TIMEOUT_W:0]   idle_sum;
  logic [usbsof_pkg::TIMEOUT_W-1:0] idle_sat;

  assign idle_sum = {1'b0, idle_time_ms}
                  + {{(usbsof_pkg::TIMEOUT_W - usbsof_pkg::PERIOD_W + 1){1'b0}}, cfg.period};
  assign idle_sat = idle_sum[usbsof_pkg::TIMEOUT_W] ? '1
                                                   : idle_sum[usbsof_pkg::TIMEOUT_W-1:0];

  always_comb begin
    last_frame_next       = last_frame;
    frame_counter_next    = frame_counter;
    counter_snapshot_next = counter_snapshot;
    active_flag_next      = active_flag;
    suspend_events_next   = suspend_events;
    idle_time_ms_next     = idle_time_ms;
    unique case (act)
      usbsof_pkg::ACT_SOF: begin
        if (frame != last_frame) begin
          last_frame_next     = frame;
          frame_counter_next  = frame_counter + 1'b1;
          suspend_events_next = '0;
          active_flag_next    = 1'b1;
        end
      end
      usbsof_pkg::ACT_SUSPEND: begin
        if (suspend_events != '1) begin
          suspend_events_next = suspend_events + 1'b1;
        end
        if (active_flag && (suspend_events_next > cfg.limit)) begin
          active_flag_next      = 1'b0;
          frame_counter_next    = '0;
          counter_snapshot_next = '0;
        end
      end
      usbsof_pkg::ACT_RESUME: begin
        suspend_events_next = '0;
      end
      default: begin
        counter_snapshot_next = frame_counter;
        if (frame_counter != counter_snapshot) begin
          idle_time_ms_next = '0;
          active_flag_next  = 1'b1;
        end else if (idle_sat >= cfg.timeout) begin
          active_flag_next  = 1'b0;
          idle_time_ms_next = '0;
        end else begin
          idle_time_ms_next = idle_sat;
        end
      end
    endcase
    res_next.link_active   = active_flag_next;
    res_next.state_changed = active_flag_next ^ active_flag;
    res_next.sof_count     = frame_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame       <= '0;
      frame_counter    <= '0;
      counter_snapshot <= '0;
      active_flag      <= 1'b0;
      suspend_events   <= '0;
      idle_time_ms     <= '0;
    end else if (step) begin
      last_frame       <= last_frame_next;
      frame_counter    <= frame_counter_next;
      counter_snapshot <= counter_snapshot_next;
      active_flag      <= active_flag_next;
      suspend_events   <= suspend_events_next;
      idle_time_ms     <= idle_time_ms_next;
    end
  end

endmodule

FILE: rtl/core/usb_sof_keepalive_detector.sv
// ----------------------------------------------------------------------------
// usb_sof_keepalive_detector
// USB bus liveness tracker driven by SOF, suspend, resume and tick items.
//
//   channel  handshake             payload
//   event    evt_valid/evt_stall   action, frame_number
//   result   res_valid/res_stall   link_active, state_changed, sof_count
//   config   cfg_we                cfg_index, cfg_data
//
// One item per cycle unless the result stalls (input reg, result reg).
// The state update runs as the item moves from input to result register.
// A stalled result holds the result register; the input register still
// takes one more item. rst clears link state and flags, loads cfg defaults.
// ----------------------------------------------------------------------------
module usb_sof_keepalive_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               evt_valid,
  output logic                               evt_stall,
  input  logic [1:0]                         action,
  input  logic [usbsof_pkg::FRAME_W-1:0]     frame_number,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               link_active,
  output logic                               state_changed,
  output logic [usbsof_pkg::COUNT_W-1:0]     sof_count,
  input  logic                               cfg_we,
  input  logic [usbsof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [usbsof_pkg::CFG_DAT_W-1:0]   cfg_data
);

  usbsof_pkg::cfg_t                cfg;
  usbsof_pkg::result_t             res_next;
  usbsof_pkg::result_t             res;
  usbsof_pkg::action_t             act;
  logic [usbsof_pkg::FRAME_W-1:0]  frame;
  logic                            in_full;
  logic                            advance;

  assign advance   = in_full && (!res_valid || !res_stall);
  assign evt_stall = in_full && !advance;

  usbsof_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  usbsof_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .act      (act),
    .frame    (frame),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (evt_valid && !evt_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      act   <= usbsof_pkg::action_t'(action);
      frame <= frame_number;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign link_active   = res.link_active;
  assign state_changed = res.state_changed;
  assign sof_count     = res.sof_count;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for usb_sof_keepalive_detector. A scoreboard class
// keeps its own copy of the liveness state and registers. It predicts link
// flag, change flag and SOF count for every accepted event and compares each
// accepted result in order. Directed events cover frame repeats, suspend
// drops, idle timeouts and extreme register values. Random SOF bursts, tick
// runs and suspend runs follow under changing settings, with random gaps on
// both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 300;

  typedef logic [usbsof_pkg::FRAME_W-1:0]   frame_t;
  typedef logic [usbsof_pkg::COUNT_W-1:0]   count_t;
  typedef logic [usbsof_pkg::PERIOD_W-1:0]  period_t;
  typedef logic [usbsof_pkg::TIMEOUT_W-1:0] timeout_t;
  typedef logic [usbsof_pkg::LIMIT_W-1:0]   limit_t;
  typedef logic [usbsof_pkg::CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [usbsof_pkg::CFG_DAT_W-1:0] cfg_dat_t;

  class sof_scoreboard;
    period_t                     period;
    timeout_t                    timeout;
    limit_t                      limit;
    frame_t                      last_frame;
    count_t                      frame_count;
    count_t                      snapshot;
    logic                        active;
    logic [7:0]                  suspends;
    timeout_t                    idle_ms;
    usbsof_pkg::result_t         pending[$];
    int unsigned                 errors;

    function void clear();
      period      = usbsof_pkg::PERIOD_RST;
      timeout     = usbsof_pkg::TIMEOUT_RST;
      limit       = usbsof_pkg::LIMIT_RST;
      last_frame  = '0;
      frame_count = '0;
      snapshot    = '0;
      active      = 1'b0;
      suspends    = '0;
      idle_ms     = '0;
      errors      = 0;
      pending.delete();
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_dat_t data);
      case (idx)
        usbsof_pkg::CFG_PERIOD:  period  = data[usbsof_pkg::PERIOD_W-1:0];
        usbsof_pkg::CFG_TIMEOUT: timeout = data[usbsof_pkg::TIMEOUT_W-1:0];
        usbsof_pkg::CFG_LIMIT:   limit   = data[usbsof_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_event(usbsof_pkg::action_t act, frame_t frame);
      logic                                was_active;
      count_t                              delta;
      logic [usbsof_pkg::TIMEOUT_W:0]      idle_sum;
      usbsof_pkg::result_t                 r;
      was_active = active;
      case (act)
        usbsof_pkg::ACT_SOF: begin
          if (frame != last_frame) begin
            last_frame  = frame;
            frame_count = frame_count + 1'b1;
            suspends    = '0;
            active      = 1'b1;
          end
        end
        usbsof_pkg::ACT_SUSPEND: begin
          if (suspends != 8'hFF) suspends = suspends + 1'b1;
          if (active && suspends > limit) begin
            active      = 1'b0;
            frame_count = '0;
            snapshot    = '0;
          end
        end
        usbsof_pkg::ACT_RESUME: suspends = '0;
        usbsof_pkg::ACT_TICK: begin
          delta    = frame_count - snapshot;
          snapshot = frame_count;
          if (delta != '0) begin
            idle_ms = '0;
            active  = 1'b1;
          end else begin
            idle_sum = {1'b0, idle_ms} + {7'b0, period};
            if (idle_sum > 17'h0FFFF) idle_sum = 17'h0FFFF;
            if (idle_sum >= {1'b0, timeout}) begin
              active   = 1'b0;
              idle_sum = '0;
            end
            idle_ms = idle_sum[usbsof_pkg::TIMEOUT_W-1:0];
          end
        end
        default: ;
      endcase
      r.link_active   = active;
      r.state_changed = (active != was_active);
      r.sof_count     = frame_count;
      pending.push_back(r);
    endfunction

    function void flag(string what, count_t want, count_t got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic got_active, logic got_changed, count_t got_count);
      usbsof_pkg::result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, expected none actual %0b %0b %0d",
                 $time, got_active, got_changed, got_count);
        return;
      end
      want = pending.pop_front();
      if (got_active !== want.link_active)
        flag("link_active", count_t'(want.link_active), count_t'(got_active));
      if (got_changed !== want.state_changed)
        flag("state_changed", count_t'(want.state_changed), count_t'(got_changed));
      if (got_count !== want.sof_count)
        flag("sof_count", want.sof_count, got_count);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 evt_valid = 1'b0;
  logic                 evt_stall;
  logic [1:0]           action = usbsof_pkg::ACT_SOF;
  frame_t               frame_number = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic                 link_active;
  logic                 state_changed;
  count_t               sof_count;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_index = usbsof_pkg::CFG_PERIOD;
  cfg_dat_t             cfg_data = '0;

  sof_scoreboard        sb;
  int unsigned          send_idle_pct = 20;
  int unsigned          recv_idle_pct = 20;
  logic                 hold_req = 1'b0;
  bit                   hold_served = 1'b0;
  int unsigned          sent_items = 0;
  int unsigned          cycles = 0;
  frame_t               frame_seq = '0;

  usb_sof_keepalive_detector uut (
    .clk          (clk),
    .rst          (rst),
    .evt_valid    (evt_valid),
    .evt_stall    (evt_stall),
    .action       (action),
    .frame_number (frame_number),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .link_active  (link_active),
    .state_changed(state_changed),
    .sof_count    (sof_count),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (evt_valid && !evt_stall)
        sb.note_event(usbsof_pkg::action_t'(action), frame_number);
      if (res_valid && !res_stall) sb.check_result(link_active, state_changed, sof_count);
    end
  end

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_event(usbsof_pkg::action_t act, frame_t frame);
    while ($urandom_range(99) < send_idle_pct) begin
      evt_valid <= 1'b0;
      @(posedge clk);
    end
    evt_valid    <= 1'b1;
    action       <= act;
    frame_number <= frame;
    do @(posedge clk); while (evt_stall);
    sent_items++;
  endtask

  task automatic settle();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(period_t period, timeout_t timeout, limit_t limit);
    cfg_idx_t idx[3];
    cfg_dat_t val[3];
    idx[0] = usbsof_pkg::CFG_PERIOD;
    idx[1] = usbsof_pkg::CFG_TIMEOUT;
    idx[2] = usbsof_pkg::CFG_LIMIT;
    // upper bits beyond the register width are don't-care
    val[0] = {6'($urandom), period};
    val[1] = timeout;
    val[2] = {8'($urandom), limit};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    period_t  period;
    timeout_t timeout;
    limit_t   limit;
    case ($urandom_range(3))
      0: period = '0;
      1: period = '1;
      2: period = period_t'($urandom_range(1, 1023));
      default: period = period_t'($urandom_range(50, 400));
    endcase
    case ($urandom_range(3))
      0: timeout = '0;
      1: timeout = '1;
      2: timeout = timeout_t'($urandom_range(1, 3000));
      default: timeout = timeout_t'($urandom);
    endcase
    case ($urandom_range(3))
      0: limit = '0;
      1: limit = 8'd254;
      2: limit = '1;
      default: limit = limit_t'($urandom_range(1, 6));
    endcase
    load_config(period, timeout, limit);
  endtask

  task automatic random_sequence();
    int unsigned len;
    int unsigned pick;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          pick = $urandom_range(9);
          if (pick < 7) frame_seq = frame_seq + 1'b1;
          else if (pick == 9) frame_seq = frame_t'($urandom);
          send_event(usbsof_pkg::ACT_SOF, frame_seq);
        end
        if ($urandom_range(9) < 7) send_event(usbsof_pkg::ACT_TICK, frame_t'($urandom));
      end
      4, 5: begin
        len = ($urandom_range(7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
        repeat (len) send_event(usbsof_pkg::ACT_TICK, frame_t'($urandom));
      end
      6, 7: begin
        // rare long run drives the suspend count into saturation
        len = ($urandom_range(39) == 0) ? 260 : $urandom_range(1, 8);
        repeat (len) send_event(usbsof_pkg::ACT_SUSPEND, frame_t'($urandom));
        if ($urandom_range(1) == 0) send_event(usbsof_pkg::ACT_RESUME, frame_t'($urandom));
      end
      8: send_event(usbsof_pkg::ACT_RESUME, frame_t'($urandom));
      default: send_event(usbsof_pkg::action_t'($urandom_range(3)), frame_t'($urandom));
    endcase
  endtask

  task automatic random_phase(int unsigned count, bit with_hold);
    int unsigned stop_at;
    int unsigned chunk_end;
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      settle();
      random_config();
      if (with_hold) hold_req <= 1'b1;
      chunk_end = sent_items + $urandom_range(80, 180);
      while (sent_items < chunk_end && sent_items < stop_at) random_sequence();
    end
    settle();
  endtask

  task automatic run_directed();
    send_event(usbsof_pkg::ACT_SOF, 11'd0);
    send_event(usbsof_pkg::ACT_TICK, 11'h7FF);
    send_event(usbsof_pkg::ACT_SOF, 11'h7FF);
    send_event(usbsof_pkg::ACT_SOF, 11'h7FF);
    send_event(usbsof_pkg::ACT_SOF, 11'd0);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    send_event(usbsof_pkg::ACT_TICK, 11'h555);
    send_event(usbsof_pkg::ACT_RESUME, 11'h2AA);
    repeat (4) send_event(usbsof_pkg::ACT_SUSPEND, 11'h7FF);
    send_event(usbsof_pkg::ACT_SUSPEND, 11'd0);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    settle();
    load_config(10'd1000, 16'd1, 8'd0);
    send_event(usbsof_pkg::ACT_SOF, 11'd1);
    send_event(usbsof_pkg::ACT_SUSPEND, 11'd0);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    send_event(usbsof_pkg::ACT_SOF, 11'd2);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    settle();
    load_config(10'd0, 16'd0, 8'd255);
    send_event(usbsof_pkg::ACT_SOF, 11'd3);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    settle();
    load_config(10'd1023, 16'd65535, 8'd254);
    send_event(usbsof_pkg::ACT_SOF, 11'd4);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    send_event(usbsof_pkg::ACT_TICK, 11'd0);
    settle();
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    send_idle_pct = 37;
    recv_idle_pct = 66;
    random_phase(650, 1'b0);
    send_idle_pct = 66;
    recv_idle_pct = 37;
    random_phase(650, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(650, 1'b1);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: usb_sof_keepalive_detector.f
rtl/core/usbsof_pkg.sv
rtl/core/usbsof_cfg.sv
rtl/core/usbsof_core.sv
rtl/core/usb_sof_keepalive_detector.sv
tb/testbench.sv
